### rtl/slrc_pkg.sv
`timescale 1ns / 1ps
// Package for the store/load reuse counter: record codes, field widths,
// parameter defaults and the token that travels along the cell row.
// Has no dependencies; every other file of the block uses it.
package slrc_pkg;

    localparam int OPERATION_W = 2;
    localparam int BLOCK_ID_W  = 24;
    localparam int ADDRESS_W   = 32;
    localparam int LENGTH_W    = 8;
    localparam int SUM_W       = 32;

    localparam int SET_DEPTH_DEFAULT    = 64;
    localparam int ADDRESS_BITS_DEFAULT = 32;

    localparam logic [OPERATION_W-1:0] OP_BREAK = 2'd0;
    localparam logic [OPERATION_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPERATION_W-1:0] OP_WRITE = 2'd2;

    // One record on its way through the row of cells. The address key
    // travels beside it, as its width follows a module parameter.
    typedef struct packed {
        logic                   valid;
        logic [OPERATION_W-1:0] operation;
        logic [BLOCK_ID_W-1:0]  block_id;
        logic [LENGTH_W-1:0]    access_length;
        logic                   hit;   // a read found its address
        logic                   done;  // a write found or took an entry
    } token_t;

endpackage

### rtl/slrc_in_if.sv
`timescale 1ns / 1ps
// Record channel of the store/load reuse counter: valid/ready plus payload.
// Depends on slrc_pkg for the field widths.
interface slrc_in_if;
    logic                             valid;
    logic                             ready;
    logic [slrc_pkg::OPERATION_W-1:0] operation;
    logic [slrc_pkg::BLOCK_ID_W-1:0]  block_id;
    logic [slrc_pkg::ADDRESS_W-1:0]   address;
    logic [slrc_pkg::LENGTH_W-1:0]    access_length;

    modport source (output valid, operation, block_id, address, access_length,
                    input ready);
    modport sink (input valid, operation, block_id, address, access_length,
                  output ready);
endinterface

### rtl/slrc_out_if.sv
`timescale 1ns / 1ps
// Result channel of the store/load reuse counter: valid/ready plus payload.
// Depends on slrc_pkg for the field widths.
interface slrc_out_if;
    logic                            valid;
    logic                            ready;
    logic [slrc_pkg::BLOCK_ID_W-1:0] owner_block;
    logic [slrc_pkg::SUM_W-1:0]      saved_bytes;
    logic                            set_overflow;

    modport source (output valid, owner_block, saved_bytes, set_overflow,
                    input ready);
    modport sink (input valid, owner_block, saved_bytes, set_overflow,
                  output ready);
endinterface

### rtl/slrc_cell.sv
`timescale 1ns / 1ps
// One entry of the address set, built as a cell of a systolic row.
// Depends on slrc_pkg for the token type and record codes.
module slrc_cell #(
    parameter int KEY_W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  slrc_pkg::token_t    tok_in,
    input  logic [KEY_W-1:0]    key_in,
    output slrc_pkg::token_t    tok_out,
    output logic [KEY_W-1:0]    key_out
);

    logic             entry_valid_reg, entry_valid_next;
    logic [KEY_W-1:0] entry_key_reg, entry_key_next;
    slrc_pkg::token_t tok_reg, tok_next;
    logic [KEY_W-1:0] key_reg;
    logic             match;
    logic             take;

    assign match = tok_in.valid && entry_valid_reg && (entry_key_reg == key_in);
    // An unresolved write takes the first free entry it meets; free entries
    // always form the tail of the row, so nothing further on can match.
    assign take  = tok_in.valid && (tok_in.operation == slrc_pkg::OP_WRITE)
                   && !tok_in.done && !entry_valid_reg;

    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        entry_key_next   = entry_key_reg;
        tok_next         = tok_in;
        if (tok_in.valid && (tok_in.operation == slrc_pkg::OP_BREAK))
        begin
            entry_valid_next = 1'b0;
        end
        else if (take)
        begin
            entry_valid_next = 1'b1;
            entry_key_next   = key_in;
        end
        if (tok_in.operation == slrc_pkg::OP_READ)
        begin
            tok_next.hit = tok_in.hit || match;
        end
        if (tok_in.operation == slrc_pkg::OP_WRITE)
        begin
            tok_next.done = tok_in.done || match || take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            tok_reg         <= '0;
        end
        else if (advance)
        begin
            entry_valid_reg <= entry_valid_next;
            tok_reg         <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            entry_key_reg <= entry_key_next;
            key_reg       <= key_in;
        end
    end

    assign tok_out = tok_reg;
    assign key_out = key_reg;

endmodule

### rtl/slrc_tail.sv
`timescale 1ns / 1ps
// Package accumulator at the end of the cell row: first block id, saturating
// byte sum, overflow flag and the result register. Depends on slrc_pkg and
// the result channel interface slrc_out_if.
module slrc_tail (
    input  logic              clk,
    input  logic              rst_n,
    input  slrc_pkg::token_t  tok_in,
    output logic              advance,
    slrc_out_if.source        results
);

    logic                            open_reg, open_next;
    logic [slrc_pkg::BLOCK_ID_W-1:0] first_reg, first_next;
    logic [slrc_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic                            ovf_reg, ovf_next;
    logic                            out_valid_reg, out_valid_next;
    logic [slrc_pkg::BLOCK_ID_W-1:0] out_owner_reg, out_owner_next;
    logic [slrc_pkg::SUM_W-1:0]      out_sum_reg, out_sum_next;
    logic                            out_ovf_reg, out_ovf_next;
    logic [slrc_pkg::SUM_W:0]        sum_wide;
    logic                            is_break;
    logic                            fire;

    assign is_break = tok_in.valid && (tok_in.operation == slrc_pkg::OP_BREAK);
    // Only a break needs the result register, so only a break waiting on a
    // full, stalled result register holds the row.
    assign advance  = !(is_break && out_valid_reg && !results.ready);
    assign fire     = advance && tok_in.valid;
    assign sum_wide = {1'b0, sum_reg}
                      + {{(slrc_pkg::SUM_W + 1 - slrc_pkg::LENGTH_W){1'b0}},
                         tok_in.access_length};

    always_comb
    begin
        open_next      = open_reg;
        first_next     = first_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_owner_next = out_owner_reg;
        out_sum_next   = out_sum_reg;
        out_ovf_next   = out_ovf_reg;
        if (fire)
        begin
            if (is_break)
            begin
                out_valid_next = 1'b1;
                out_owner_next = open_reg ? first_reg : tok_in.block_id;
                out_sum_next   = sum_reg;
                out_ovf_next   = ovf_reg;
                open_next      = 1'b0;
                sum_next       = '0;
                ovf_next       = 1'b0;
            end
            else
            begin
                if (!open_reg)
                begin
                    open_next  = 1'b1;
                    first_next = tok_in.block_id;
                end
                if ((tok_in.operation == slrc_pkg::OP_READ) && tok_in.hit)
                begin
                    sum_next = sum_wide[slrc_pkg::SUM_W]
                               ? {slrc_pkg::SUM_W{1'b1}}
                               : sum_wide[slrc_pkg::SUM_W-1:0];
                end
                if ((tok_in.operation == slrc_pkg::OP_WRITE) && !tok_in.done)
                begin
                    ovf_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            first_reg     <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            open_reg      <= open_next;
            first_reg     <= first_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_owner_reg <= out_owner_next;
        out_sum_reg   <= out_sum_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.owner_block  = out_owner_reg;
    assign results.saved_bytes  = out_sum_reg;
    assign results.set_overflow = out_ovf_reg;

endmodule

### rtl/store_load_reuse_counter.sv
`timescale 1ns / 1ps
// Store/load reuse counter, top level.
// Records arrive on the records channel (valid/ready): a frame break, a memory
// read or a memory write, each with block id, address and access length.
// Write addresses fill a duplicate-free set of SET_DEPTH entries; reads that
// hit the set add their length to a saturating byte sum. Each frame break
// produces one beat on the results channel with the package's owner block,
// the saved byte sum and the overflow flag, then clears the set and the sum.
// The set is a row of SET_DEPTH cells; while the row advances, every record
// walks it one cell per cycle, so a write is always ahead of any later read
// or write at every cell, and a break clears each cell as it passes.
// Throughput is one record per cycle while the row is not stopped. A break's
// record is loaded into the first cell when its beat is accepted, then passes
// through the rest of the row and into the result register, from which its
// result is offered.
// Reset empties the set, the sum and the row, and drops any pending result.
// If the receiver stalls, reads and writes keep flowing; only a break that
// reaches the end of the row while an unread result is held stops the row,
// and then records ready drops until the result beat is taken.
// Dependencies: slrc_pkg, slrc_in_if, slrc_out_if, slrc_cell, slrc_tail.
module store_load_reuse_counter #(
    parameter int SET_DEPTH    = slrc_pkg::SET_DEPTH_DEFAULT,
    parameter int ADDRESS_BITS = slrc_pkg::ADDRESS_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    slrc_in_if.sink     records,
    slrc_out_if.source  results
);

    // The address field is 32 bits wide, so bits above that always compare
    // as zero and need no storage.
    localparam int KEY_W = (ADDRESS_BITS < slrc_pkg::ADDRESS_W)
                           ? ADDRESS_BITS : slrc_pkg::ADDRESS_W;

    slrc_pkg::token_t tok_head;
    slrc_pkg::token_t tok_chain [0:SET_DEPTH];
    logic [KEY_W-1:0] key_chain [0:SET_DEPTH];
    logic             advance;

    // The row advances as a whole; a record is taken whenever it moves.
    assign records.ready = advance;

    always_comb
    begin
        tok_head               = '0;
        tok_head.valid         = records.valid;
        tok_head.operation     = records.operation;
        tok_head.block_id      = records.block_id;
        tok_head.access_length = records.access_length;
        tok_head.hit           = 1'b0;
        tok_head.done          = 1'b0;
    end

    assign tok_chain[0] = tok_head;
    assign key_chain[0] = records.address[KEY_W-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < SET_DEPTH; gi++)
        begin : g_cell
            slrc_cell #(
                .KEY_W (KEY_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .tok_in  (tok_chain[gi]),
                .key_in  (key_chain[gi]),
                .tok_out (tok_chain[gi+1]),
                .key_out (key_chain[gi+1])
            );
        end
    endgenerate

    // The key leaving the last cell is not needed: the record's outcome is
    // fully carried in its hit and done flags by then.
    slrc_tail u_tail (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_in  (tok_chain[SET_DEPTH]),
        .advance (advance),
        .results (results)
    );

endmodule
